FILE: rtl/csv_line_field_parser_macros.svh
// Assertion macros for the CSV line field parser.
`ifndef CSV_LINE_FIELD_PARSER_MACROS_SVH
`define CSV_LINE_FIELD_PARSER_MACROS_SVH

// Same-cycle implication, quiet while reset is high.
`define CSVLFP_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("csv parser: same-cycle check failed");

// Next-cycle implication, quiet while reset is high.
`define CSVLFP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("csv parser: next-cycle check failed");

`endif

FILE: rtl/csvlfp_pkg.sv
`timescale 1ns / 1ps

package csvlfp_pkg;

  localparam int unsigned COL_W    = 12;
  localparam int unsigned COUNT_W  = 13;
  localparam int unsigned LEN_W    = 16;
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned MAX_COLUMNS = 4096;

  localparam logic [CHAR_W-1:0] CH_CR = 8'd13;
  localparam logic [CHAR_W-1:0] CH_LF = 8'd10;

  localparam logic [LEN_W-1:0]  DEFAULT_MAX_FIELD = 16'd32000;
  localparam logic [CHAR_W-1:0] DEFAULT_SEPARATOR = 8'd44;
  localparam logic [CHAR_W-1:0] DEFAULT_QUOTE     = 8'd34;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FIELD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEPARATOR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_QUOTE     = 2'd2;

  typedef enum logic [1:0] {
    KIND_DATA     = 2'd0,
    KIND_COL_DONE = 2'd1,
    KIND_LINE     = 2'd2,
    KIND_ERROR    = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ERR_FIELD_LONG  = 3'd0,
    ERR_QUOTE_AFTER = 3'd1,
    ERR_TEXT_AFTER  = 3'd2,
    ERR_UNCLOSED    = 3'd3,
    ERR_COLUMNS     = 3'd4
  } err_t;

endpackage

FILE: rtl/csv_line_field_parser.sv
`timescale 1ns / 1ps
//  channel | handshake           | payload
//  --------+---------------------+--------------------------------------------
//  in      | in_valid / in_stall | in_byte, stream_end
//  out     | out_valid/out_stall | kind, column, out_byte, column_count,
//          |                     | error_code
//  cfg     | cfg_write           | cfg_index, cfg_data
//
//  One item per cycle while results do not stall; a result goes through the
//  input register and then the result register. Line state advances as the
//  input register hands its item on. rst is synchronous, active high: default
//  configuration, clean line state, both valid flags low.
//  A stalled result holds the result register; an item with a result then
//  waits in the input register and raises in_stall.
`include "csv_line_field_parser_macros.svh"

module csv_line_field_parser (
  input  logic                                clk,
  input  logic                                rst,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [csvlfp_pkg::CHAR_W-1:0]       in_byte,
  input  logic                                stream_end,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [1:0]                          kind,
  output logic [csvlfp_pkg::COL_W-1:0]        column,
  output logic [csvlfp_pkg::CHAR_W-1:0]       out_byte,
  output logic [csvlfp_pkg::COUNT_W-1:0]      column_count,
  output logic [2:0]                          error_code,
  // configuration write port
  input  logic                                cfg_write,
  input  logic [csvlfp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [csvlfp_pkg::LEN_W-1:0]        cfg_data
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [csvlfp_pkg::LEN_W-1:0]  max_field_length;
  logic [csvlfp_pkg::CHAR_W-1:0] separator_char;
  logic [csvlfp_pkg::CHAR_W-1:0] quote_char;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_field_length <= csvlfp_pkg::DEFAULT_MAX_FIELD;
      separator_char   <= csvlfp_pkg::DEFAULT_SEPARATOR;
      quote_char       <= csvlfp_pkg::DEFAULT_QUOTE;
    end else if (cfg_write) begin
      case (cfg_index)
        csvlfp_pkg::CFG_MAX_FIELD: max_field_length <= cfg_data;
        csvlfp_pkg::CFG_SEPARATOR: separator_char   <= cfg_data[csvlfp_pkg::CHAR_W-1:0];
        csvlfp_pkg::CFG_QUOTE:     quote_char       <= cfg_data[csvlfp_pkg::CHAR_W-1:0];
        default: ;  // unused index: drop the write
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  logic                          in_q_vld;
  logic [csvlfp_pkg::CHAR_W-1:0] in_q_byte;
  logic                          in_q_end;
  logic                          proc_fire;
  logic                          out_ready;
  logic                          in_fire;

  assign out_ready = !out_valid || !out_stall;
  assign in_stall  = in_q_vld && !proc_fire;
  assign in_fire   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_vld <= 1'b0;
    end else if (in_fire) begin
      in_q_vld <= 1'b1;
    end else if (proc_fire) begin
      in_q_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_q_byte <= in_byte;
      in_q_end  <= stream_end;
    end
  end

  // ---------------------------------------------------------------------------
  // Line state
  // ---------------------------------------------------------------------------
  logic                         inside_quotes, inside_quotes_next;
  logic                         after_close_quote, after_close_quote_next;
  logic [csvlfp_pkg::COL_W-1:0] column_index, column_index_next;
  logic [csvlfp_pkg::LEN_W-1:0] field_length, field_length_next;
  logic                         discard_to_line_end, discard_to_line_end_next;

  // Result of the item in the input register
  logic                           res_vld;
  csvlfp_pkg::kind_t              res_kind;
  logic [csvlfp_pkg::COL_W-1:0]   res_col;
  logic [csvlfp_pkg::CHAR_W-1:0]  res_byte;
  logic [csvlfp_pkg::COUNT_W-1:0] res_count;
  csvlfp_pkg::err_t               res_err;

  // Byte classification
  logic line_end;
  logic is_sep;
  logic is_quote;
  logic is_data;
  logic at_last_col;
  logic line_has_tail;
  logic line_clean;
  logic do_next;
  logic err_hit;
  csvlfp_pkg::err_t err_code;

  assign line_end = in_q_end || (in_q_byte == csvlfp_pkg::CH_LF);
  assign is_sep   = (in_q_byte == separator_char);
  assign is_quote = (in_q_byte == quote_char);
  // The separator counts as data inside quotes; CR is otherwise never data.
  assign is_data  = (!is_sep && !is_quote && (in_q_byte != csvlfp_pkg::CH_CR)) ||
                    (is_sep && inside_quotes);

  // Advancing past the last column raises the overflow error instead.
  assign at_last_col = ({1'b0, column_index} + csvlfp_pkg::COUNT_W'(1)) >=
                       csvlfp_pkg::COUNT_W'(csvlfp_pkg::MAX_COLUMNS);

  // The line count includes an open last column unless a closing quote
  // already reported it or the line is empty.
  assign line_has_tail = !after_close_quote &&
                         ((column_index != '0) || (field_length != '0));

  assign line_clean = (column_index == '0) && (field_length == '0) &&
                      !inside_quotes && !discard_to_line_end;

  always_comb begin
    res_vld   = 1'b0;
    res_kind  = csvlfp_pkg::KIND_DATA;
    res_col   = '0;
    res_byte  = '0;
    res_count = '0;
    res_err   = csvlfp_pkg::ERR_FIELD_LONG;

    inside_quotes_next       = inside_quotes;
    after_close_quote_next   = after_close_quote;
    column_index_next        = column_index;
    field_length_next        = field_length;
    discard_to_line_end_next = discard_to_line_end;

    do_next  = 1'b0;
    err_hit  = 1'b0;
    err_code = csvlfp_pkg::ERR_FIELD_LONG;

    if (line_end) begin
      // Clear the whole line state; after an error the line end is silent.
      inside_quotes_next       = 1'b0;
      after_close_quote_next   = 1'b0;
      column_index_next        = '0;
      field_length_next        = '0;
      discard_to_line_end_next = 1'b0;
      if (!discard_to_line_end) begin
        res_vld = 1'b1;
        if (inside_quotes) begin
          res_kind = csvlfp_pkg::KIND_ERROR;
          res_col  = column_index;
          res_err  = csvlfp_pkg::ERR_UNCLOSED;
        end else begin
          res_kind  = csvlfp_pkg::KIND_LINE;
          res_count = {1'b0, column_index} +
                      csvlfp_pkg::COUNT_W'(line_has_tail);
        end
      end
    end else if (!discard_to_line_end) begin
      if (is_data) begin
        if (after_close_quote && !inside_quotes) begin
          err_hit  = 1'b1;
          err_code = csvlfp_pkg::ERR_TEXT_AFTER;
        end else if (field_length > max_field_length) begin
          err_hit  = 1'b1;
          err_code = csvlfp_pkg::ERR_FIELD_LONG;
        end else begin
          if (field_length != '1) begin
            field_length_next = field_length + csvlfp_pkg::LEN_W'(1);
          end
          res_vld  = 1'b1;
          res_kind = csvlfp_pkg::KIND_DATA;
          res_col  = column_index;
          res_byte = in_q_byte;
        end
      end else if (is_quote) begin
        if (inside_quotes) begin
          inside_quotes_next     = 1'b0;
          after_close_quote_next = 1'b1;
          do_next                = 1'b1;
        end else if (field_length != '0) begin
          err_hit  = 1'b1;
          err_code = csvlfp_pkg::ERR_QUOTE_AFTER;
        end else begin
          inside_quotes_next = 1'b1;
        end
      end else if (is_sep) begin
        if (!after_close_quote) begin
          do_next = 1'b1;
        end else if (field_length != '0) begin
          err_hit  = 1'b1;
          err_code = csvlfp_pkg::ERR_TEXT_AFTER;
        end else begin
          // separator right after a closing quote: just drop the mark
          after_close_quote_next = 1'b0;
        end
      end
      // plain CR: drop without a result
    end

    // Finish the current column, or flag overflow.
    if (do_next) begin
      if (at_last_col) begin
        err_hit  = 1'b1;
        err_code = csvlfp_pkg::ERR_COLUMNS;
      end else begin
        column_index_next = column_index + csvlfp_pkg::COL_W'(1);
        field_length_next = '0;
        res_vld  = 1'b1;
        res_kind = csvlfp_pkg::KIND_COL_DONE;
        res_col  = column_index;
      end
    end

    // Report the error and skip the rest of the line.
    if (err_hit) begin
      res_vld                  = 1'b1;
      res_kind                 = csvlfp_pkg::KIND_ERROR;
      res_col                  = column_index;
      res_err                  = err_code;
      discard_to_line_end_next = 1'b1;
    end
  end

  // Advance the input register when its result, if any, has a free slot.
  assign proc_fire = in_q_vld && (!res_vld || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      inside_quotes       <= 1'b0;
      after_close_quote   <= 1'b0;
      column_index        <= '0;
      field_length        <= '0;
      discard_to_line_end <= 1'b0;
    end else if (proc_fire) begin
      inside_quotes       <= inside_quotes_next;
      after_close_quote   <= after_close_quote_next;
      column_index        <= column_index_next;
      field_length        <= field_length_next;
      discard_to_line_end <= discard_to_line_end_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= proc_fire && res_vld;
    end
  end

  // Load only on a new transfer; hold while stalled.
  always_ff @(posedge clk) begin
    if (out_ready && proc_fire && res_vld) begin
      kind         <= res_kind;
      column       <= res_col;
      out_byte     <= res_byte;
      column_count <= res_count;
      error_code   <= res_err;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // While skipping to the line end, only the line end may pass, and silently.
  `CSVLFP_ASSERT_SAME(a_discard_quiet, clk, rst, in_q_vld && discard_to_line_end, !res_vld)
  // A line end leaves a clean line state behind.
  `CSVLFP_ASSERT_NEXT(a_line_end_clears, clk, rst, proc_fire && line_end, line_clean)
  // An item held in the input register is neither lost nor overwritten.
  `CSVLFP_ASSERT_NEXT(a_input_held, clk, rst, in_stall, in_q_vld && $stable({in_q_byte, in_q_end}))

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import csvlfp_pkg::*;

  // Run guard and pacing.
  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam int unsigned LONG_HOLD     = 200;
  // A result passes the input and result registers; leave margin for dropped bytes.
  localparam int unsigned SETTLE_CYCLES = 8;

  typedef struct packed {
    kind_t              kind;
    logic [COL_W-1:0]   column;
    logic [CHAR_W-1:0]  data;
    logic [COUNT_W-1:0] count;
    err_t               err;
  } parse_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [CHAR_W-1:0]    in_byte = '0;
  logic                 stream_end = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [1:0]           kind;
  logic [COL_W-1:0]     column;
  logic [CHAR_W-1:0]    out_byte;
  logic [COUNT_W-1:0]   column_count;
  logic [2:0]           error_code;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [LEN_W-1:0]     cfg_data = '0;

  csv_line_field_parser uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .stream_end   (stream_end),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .column       (column),
    .out_byte     (out_byte),
    .column_count (column_count),
    .error_code   (error_code),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // Shadow copy of the parser configuration and line state.
  logic [LEN_W-1:0]  lim_len;
  logic [CHAR_W-1:0] sep_ch;
  logic [CHAR_W-1:0] quote_ch;
  logic              in_quotes;
  logic              quote_closed;
  logic              skip_line;
  logic [COL_W-1:0]  col_idx;
  logic [LEN_W-1:0]  field_len;

  // Results the parser still owes us, oldest first.
  parse_result_t pending_results[$];

  int  errors = 0;
  int  sent_items = 0;
  int  cycle_count = 0;
  bit  idle_in = 1'b1;
  bit  idle_out = 1'b1;
  bit  hold_req = 1'b0;

  // ---------------------------------------------------------------------------
  // Line parser prediction
  // ---------------------------------------------------------------------------
  function automatic void clear_line_state();
    in_quotes    = 1'b0;
    quote_closed = 1'b0;
    col_idx      = '0;
    field_len    = '0;
    skip_line    = 1'b0;
  endfunction

  // Report an error at the current column and drop the rest of the line.
  function automatic bit flag_error(input err_t code, output parse_result_t r);
    r = '0;
    r.kind   = KIND_ERROR;
    r.column = col_idx;
    r.err    = code;
    skip_line = 1'b1;
    return 1'b1;
  endfunction

  // Finish the current column; the last legal index cannot advance.
  function automatic bit close_column(output parse_result_t r);
    if (int'(col_idx) + 1 >= int'(MAX_COLUMNS))
      return flag_error(ERR_COLUMNS, r);
    r = '0;
    r.kind    = KIND_COL_DONE;
    r.column  = col_idx;
    col_idx   = col_idx + 1'b1;
    field_len = '0;
    return 1'b1;
  endfunction

  // Advance the shadow state by one byte; return 1 when a result is due.
  function automatic bit parse_step(input logic [CHAR_W-1:0] ch, input logic fin,
                                    output parse_result_t r);
    r = '0;
    // Line end: a newline byte or the stream end mark.
    if (fin || ch == CH_LF) begin
      if (skip_line) begin
        clear_line_state();
        return 1'b0;
      end
      if (in_quotes) begin
        r.kind   = KIND_ERROR;
        r.column = col_idx;
        r.err    = ERR_UNCLOSED;
        clear_line_state();
        return 1'b1;
      end
      r.kind  = KIND_LINE;
      r.count = {1'b0, col_idx};
      // Empty lines and lines closed by a quote add no trailing column.
      if (!quote_closed && (col_idx != '0 || field_len != '0))
        r.count = r.count + 1'b1;
      clear_line_state();
      return 1'b1;
    end
    if (skip_line)
      return 1'b0;
    // Plain text, or a separator protected by quotes.
    if ((ch != sep_ch && ch != quote_ch && ch != CH_CR) || (ch == sep_ch && in_quotes)) begin
      if (quote_closed && !in_quotes)
        return flag_error(ERR_TEXT_AFTER, r);
      if (field_len > lim_len)
        return flag_error(ERR_FIELD_LONG, r);
      if (field_len != '1)
        field_len = field_len + 1'b1;
      r.kind   = KIND_DATA;
      r.column = col_idx;
      r.data   = ch;
      return 1'b1;
    end
    if (ch == quote_ch) begin
      if (in_quotes) begin
        in_quotes    = 1'b0;
        quote_closed = 1'b1;
        return close_column(r);
      end
      if (field_len != '0)
        return flag_error(ERR_QUOTE_AFTER, r);
      in_quotes = 1'b1;
      return 1'b0;
    end
    if (ch == sep_ch) begin
      if (!quote_closed)
        return close_column(r);
      if (field_len != '0)
        return flag_error(ERR_TEXT_AFTER, r);
      // The column was already reported by its closing quote.
      quote_closed = 1'b0;
      return 1'b0;
    end
    // Lone carriage return: drop.
    return 1'b0;
  endfunction

  // Predict on every input transfer.
  always @(posedge clk) begin : predict_results
    parse_result_t r;
    if (!rst && in_valid && !in_stall) begin
      if (parse_step(in_byte, stream_end, r))
        pending_results.insert(pending_results.size(), r);
    end
  end

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  task automatic report_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : check_results
    parse_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with none pending, expected nothing actual kind %0d",
                 $time, kind);
        errors++;
      end else begin
        want = pending_results.pop_front();
        report_field("kind", want.kind, kind);
        report_field("column", want.column, column);
        report_field("out_byte", want.data, out_byte);
        report_field("column_count", want.count, column_count);
        report_field("error_code", want.err, error_code);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stall bursts, or one long hold on request
  // ---------------------------------------------------------------------------
  initial begin : drive_out_stall
    forever begin
      @(posedge clk);
      if (hold_req) begin
        // Hold off long enough for the parser to fill and stall its input.
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else if (idle_out && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Run guard.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------
  // Offer one byte and hold it until the transfer; valid stays high on return
  // so back-to-back items do not toggle it.
  task automatic send_char(input logic [CHAR_W-1:0] ch, input logic fin);
    if (idle_in && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_byte    <= ch;
    stream_end <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_items++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++)
      send_char(s[i], 1'b0);
  endtask

  // End the stream; the byte lane carries noise.
  task automatic send_stream_end();
    send_char(CHAR_W'($urandom_range(0, 255)), 1'b1);
  endtask

  // Drop valid, drain every pending result, then let dropped bytes retire.
  task automatic settle_block();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all three registers while the parser is idle.
  task automatic set_config(input logic [LEN_W-1:0] max_len, input logic [CHAR_W-1:0] sep,
                            input logic [CHAR_W-1:0] quote);
    settle_block();
    cfg_write <= 1'b1;
    cfg_index <= CFG_MAX_FIELD;
    cfg_data  <= max_len;
    @(posedge clk);
    lim_len = max_len;
    cfg_index <= CFG_SEPARATOR;
    cfg_data  <= LEN_W'(sep);
    @(posedge clk);
    sep_ch = sep;
    cfg_index <= CFG_QUOTE;
    cfg_data  <= LEN_W'(quote);
    @(posedge clk);
    quote_ch = quote;
    cfg_write <= 1'b0;
  endtask

  // Text byte for a field body; quoted bodies favor the separator.
  function automatic logic [CHAR_W-1:0] pick_text(input bit quoted);
    logic [CHAR_W-1:0] b;
    if (quoted && sep_ch != quote_ch && sep_ch != CH_LF && $urandom_range(0, 4) == 0)
      return sep_ch;
    do
      b = CHAR_W'($urandom_range(0, 255));
    while (b == CH_LF || b == quote_ch || (!quoted && (b == sep_ch || b == CH_CR)));
    return b;
  endfunction

  // Well-formed line with random fields and random content.
  task automatic send_csv_line();
    int  nfields;
    int  flen;
    bit  quoted;
    nfields = $urandom_range(0, 5);
    for (int f = 0; f < nfields; f++) begin
      if (f != 0)
        send_char(sep_ch, 1'b0);
      quoted = ($urandom_range(0, 2) == 0);
      flen   = $urandom_range(0, 6);
      if (quoted)
        send_char(quote_ch, 1'b0);
      for (int i = 0; i < flen; i++)
        send_char(pick_text(quoted), 1'b0);
      if (quoted)
        send_char(quote_ch, 1'b0);
    end
    case ($urandom_range(0, 5))
      0: send_stream_end();
      1: begin
        send_char(CH_CR, 1'b0);
        send_char(CH_LF, 1'b0);
      end
      default: send_char(CH_LF, 1'b0);
    endcase
  endtask

  // Broken line: random bytes rich in control characters.
  task automatic send_noise_line();
    int n;
    n = $urandom_range(1, 10);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 7))
        0: send_char(sep_ch, 1'b0);
        1: send_char(quote_ch, 1'b0);
        2: send_char(CH_CR, 1'b0);
        default: send_char(CHAR_W'($urandom_range(0, 255)), 1'b0);
      endcase
    end
    if ($urandom_range(0, 1) == 0)
      send_char(CH_LF, 1'b0);
    else
      send_stream_end();
  endtask

  task automatic send_random_lines(input int n);
    int start;
    start = sent_items;
    while (sent_items - start < n) begin
      if ($urandom_range(0, 4) == 0)
        send_noise_line();
      else
        send_csv_line();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Quoted separators, CR drop, doubled quotes opening a new column, empty line.
  task automatic test_quoted_fields();
    set_config(DEFAULT_MAX_FIELD, DEFAULT_SEPARATOR, DEFAULT_QUOTE);
    send_text("a,\"b,\"\r\n");
    send_text("\"p\"\"q\",r");
    send_stream_end();
    send_char(CH_LF, 1'b0);
  endtask

  // Quote after text, text after a closing quote and an unclosed quote, plus the extreme byte values.
  task automatic test_malformed_lines();
    send_text("x\"\n");
    send_text("\"q\"z");
    send_stream_end();
    send_text("\"\n");
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b0);
    send_stream_end();
  endtask

  // Field length limit at zero, then a limit of 65534 on a short field.
  task automatic test_field_limits();
    set_config('0, DEFAULT_SEPARATOR, DEFAULT_QUOTE);
    send_text("ab\n");
    send_text("c,d\n");
    set_config(16'd65534, DEFAULT_SEPARATOR, DEFAULT_QUOTE);
    send_text("abcdef\n");
  endtask

  // Separator and quote at the byte extremes, then CR as the separator.
  task automatic test_custom_chars();
    set_config(16'd4, 8'hFF, 8'h00);
    send_char(8'h00, 1'b0);
    send_char("x", 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char("y", 1'b0);
    send_stream_end();
    set_config('0, CH_CR, 8'hFF);
    send_text("a\rb\n");
  endtask

  // Widest legal line, then one separator too many.
  task automatic test_column_limit();
    set_config(DEFAULT_MAX_FIELD, DEFAULT_SEPARATOR, DEFAULT_QUOTE);
    idle_in  = 1'b0;
    idle_out = 1'b0;
    repeat (MAX_COLUMNS - 1) send_char(DEFAULT_SEPARATOR, 1'b0);
    send_char(CH_LF, 1'b0);
    repeat (MAX_COLUMNS) send_char(DEFAULT_SEPARATOR, 1'b0);
    send_char(CH_LF, 1'b0);
    idle_in  = 1'b1;
    idle_out = 1'b1;
  endtask

  // Long receiver hold while the sender keeps offering data bytes.
  task automatic test_backpressure();
    settle_block();
    idle_in  = 1'b0;
    hold_req = 1'b1;
    repeat (60) send_char(pick_text(1'b0), 1'b0);
    send_char(CH_LF, 1'b0);
    idle_in = 1'b1;
    // Pause the sender until the parser has delivered everything.
    settle_block();
  endtask

  // Random lines under several settings; the last stretch runs without idling.
  task automatic test_random_traffic();
    set_config(LEN_W'($urandom_range(2, 12)), DEFAULT_SEPARATOR, DEFAULT_QUOTE);
    send_random_lines(400);
    set_config(16'd65534, 8'd9, 8'd39);
    send_random_lines(350);
    set_config(LEN_W'($urandom_range(0, 20)), CHAR_W'($urandom_range(0, 255)),
               CHAR_W'($urandom_range(0, 255)));
    send_random_lines(350);
    set_config(DEFAULT_MAX_FIELD, DEFAULT_SEPARATOR, DEFAULT_QUOTE);
    idle_in  = 1'b0;
    idle_out = 1'b0;
    send_random_lines(400);
  endtask

  initial begin
    lim_len  = DEFAULT_MAX_FIELD;
    sep_ch   = DEFAULT_SEPARATOR;
    quote_ch = DEFAULT_QUOTE;
    clear_line_state();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_quoted_fields();
    test_malformed_lines();
    test_field_limits();
    test_custom_chars();
    test_column_limit();
    test_backpressure();
    test_random_traffic();
    settle_block();
    if (errors == 0 && pending_results.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
